### rtl/assert_macros.svh
// Assertion macros included by the tracker core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
// Next-cycle implication checked outside reset
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`endif

### rtl/fst_pkg.sv
// Package with types and constants of the flow session tracker
`timescale 1ns / 1ps
`default_nettype none
package fst_pkg;
  localparam int Sessions = 1024;
  localparam int SlotW = $clog2(Sessions);
  localparam int CntW = 48;
  localparam int KeyW = 104;
  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};
  localparam logic [1:0] CfgTimeout = 2'd0;
  localparam logic [1:0] CfgTcp = 2'd1;
  localparam logic [1:0] CfgUdp = 2'd2;
  localparam logic [1:0] RouteDrop = 2'd0;
  localparam logic [1:0] RouteTcp = 2'd1;
  localparam logic [1:0] RouteUdp = 2'd2;
  localparam int InW = 128;
  localparam int OutW = 112;
endpackage
`default_nettype wire

### rtl/flow_session_tracker_core.sv
// Top level of the flow session tracker: session table, lookup and aging
`timescale 1ns / 1ps
`default_nettype none
// Flow session tracker. Sessions live in block memories (key, deadline, two
// counter memories of two entries per slot). A packet beat scans the slots
// through the key memory one entry per cycle until a hit; on a miss it then
// scans the live bits for a free slot. A hit or a new session goes on to a
// read-modify-write of the counters (S_CRD, then S_CWR) before the result;
// a packet against a full table gets a route-only result after both scans.
// A tick beat sweeps all 1024 slots once, one per cycle, freeing aged ones.
// Slot live bits are flip-flops cleared by reset, so no clearing pass exists.
// A result waits in an output register; no new beat is taken until it leaves.
module flow_session_tracker_core (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // src_addr[31:0], dst_addr[63:32], l4_src[79:64], l4_dst[95:80],
  // protocol[103:96], packet_length[119:104], zero fill
  input  wire logic [fst_pkg::InW-1:0] in_tdata,
  input  wire logic in_tuser,   // kind
  output logic      out_tvalid,
  input  wire logic out_tready,
  // route[1:0], tracked[2], is_new[3], slot_index[13:4], direction[14],
  // packet_total[62:15], byte_total[110:63], zero fill
  output logic [fst_pkg::OutW-1:0] out_tdata,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [9:0] cfg_wdata
);
  import fst_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [2:0] {S_IDLE, S_MATCH, S_FREE, S_CRD, S_CWR, S_TICK, S_OUT} st_t;
  st_t st_r;

  logic [9:0] tmo_r;
  logic [7:0] tcp_r, udp_r;
  logic [31:0] now_r;
  logic [Sessions-1:0] live_r;

  logic [KeyW-1:0] key_mem [Sessions];
  logic [31:0] dl_mem [Sessions];
  logic [CntW-1:0] pc_mem [2*Sessions];
  logic [CntW-1:0] bc_mem [2*Sessions];

  logic [KeyW-1:0] pkey_r;
  logic [15:0] len_r;
  logic [1:0] route_r;
  logic [SlotW:0] cnt_r;      // scan position and read address, one ahead of the slot being compared
  logic [SlotW-1:0] slot_r;
  logic dir_r, fresh_r, rd_ok_r;
  logic [SlotW-1:0] rd_slot_r;
  logic [KeyW-1:0] key_q;
  logic [31:0] dl_q;
  logic [CntW-1:0] pc_q, bc_q;
  logic [OutW-1:0] out_r;

  // key layout: src, dst, sport, dport, proto from low bits
  logic [KeyW-1:0] swap_key;
  assign swap_key = {pkey_r[103:96], pkey_r[79:64], pkey_r[95:80],
                     pkey_r[31:0], pkey_r[63:32]};

  logic [SlotW-1:0] raddr;
  assign raddr = cnt_r[SlotW-1:0];

  logic [1:0] rte;
  always_comb begin
    if (in_tdata[103:96] == tcp_r) rte = RouteTcp;
    else if (in_tdata[103:96] == udp_r) rte = RouteUdp;
    else rte = RouteDrop;
  end

  logic [CntW-1:0] pc_n, bc_n;
  logic [CntW:0] psum, bsum;
  assign psum = {1'b0, (fresh_r ? '0 : pc_q)} + 1'b1;
  assign bsum = {1'b0, (fresh_r ? '0 : bc_q)} + {{(CntW-15){1'b0}}, len_r};
  assign pc_n = psum[CntW] ? CntMax : psum[CntW-1:0];
  assign bc_n = bsum[CntW] ? CntMax : bsum[CntW-1:0];

  logic [31:0] age;
  assign age = now_r - dl_q;

  assign in_tready = (st_r == S_IDLE);
  assign out_tvalid = (st_r == S_OUT);
  assign out_tdata = out_r;

  always_ff @(posedge clk) begin
    key_q <= key_mem[raddr];
    dl_q <= dl_mem[raddr];
    pc_q <= pc_mem[{slot_r, dir_r}];
    bc_q <= bc_mem[{slot_r, dir_r}];
    rd_slot_r <= raddr;
    // a new session starts with the reverse direction counters at zero
    if (st_r == S_CRD && fresh_r) begin
      pc_mem[{slot_r, 1'b1}] <= '0;
      bc_mem[{slot_r, 1'b1}] <= '0;
    end
    if (st_r == S_CWR) begin
      pc_mem[{slot_r, dir_r}] <= pc_n;
      bc_mem[{slot_r, dir_r}] <= bc_n;
      dl_mem[slot_r] <= now_r + {22'd0, tmo_r};
      if (fresh_r) key_mem[slot_r] <= pkey_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      tmo_r <= 10'd3; tcp_r <= 8'd6; udp_r <= 8'd17;
      now_r <= '0; live_r <= '0; cnt_r <= '0; rd_ok_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CfgTimeout: tmo_r <= cfg_wdata;
          CfgTcp: tcp_r <= cfg_wdata[7:0];
          CfgUdp: udp_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      case (st_r)
        S_IDLE: begin
          cnt_r <= '0; rd_ok_r <= 1'b0;
          if (in_tvalid) begin
            pkey_r <= in_tdata[KeyW-1:0];
            len_r <= in_tdata[119:104];
            route_r <= rte;
            if (in_tuser) begin
              now_r <= now_r + 32'd1;
              st_r <= S_TICK;
            end else st_r <= S_MATCH;
          end
        end
        S_MATCH: begin
          if (rd_ok_r && live_r[rd_slot_r] && key_q[103:96] == pkey_r[103:96] &&
              (key_q == pkey_r || key_q == swap_key)) begin
            slot_r <= rd_slot_r; dir_r <= (key_q != pkey_r); fresh_r <= 1'b0;
            st_r <= S_CRD;
          end else if (cnt_r == (SlotW+1)'(Sessions)) begin
            cnt_r <= '0; st_r <= S_FREE;
          end else begin
            cnt_r <= cnt_r + 1'b1; rd_ok_r <= 1'b1;
          end
        end
        S_FREE: begin
          if (!live_r[raddr]) begin
            slot_r <= raddr; dir_r <= 1'b0; fresh_r <= 1'b1;
            live_r[raddr] <= 1'b1; st_r <= S_CRD;
          end else if (cnt_r == (SlotW+1)'(Sessions-1)) begin
            out_r <= {{(OutW-2){1'b0}}, route_r};
            st_r <= S_OUT;
          end else cnt_r <= cnt_r + 1'b1;
        end
        S_CRD: st_r <= S_CWR;
        S_CWR: begin
          out_r <= {{(OutW-111){1'b0}}, bc_n, pc_n, dir_r, 10'(slot_r),
                    fresh_r, 1'b1, route_r};
          st_r <= S_OUT;
        end
        S_TICK: begin
          if (rd_ok_r && live_r[rd_slot_r] && !age[31]) live_r[rd_slot_r] <= 1'b0;
          if (cnt_r == (SlotW+1)'(Sessions)) begin
            if (rd_ok_r) begin
              rd_ok_r <= 1'b0; st_r <= S_IDLE;
            end else rd_ok_r <= 1'b1;
          end else begin
            cnt_r <= cnt_r + 1'b1; rd_ok_r <= 1'b1;
          end
        end
        S_OUT: if (out_tready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `CHK_IMPL(a_one_side, clk, rst_n, out_tvalid, !in_tready)
  `CHK_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `CHK_IMPL(a_untracked_zero, clk, rst_n, out_tvalid && !out_tdata[2], out_tdata[110:3] == '0)
endmodule
`default_nettype wire

### dv/flow_session_tracker_core_test.sv
// Self-checking bench for the flow session tracker: random and directed beats vs a session model
`timescale 1ns / 1ps
import fst_pkg::*;

typedef struct {
  logic [1:0]      route;
  logic            tracked;
  logic            is_new;
  logic [9:0]      slot;
  logic            dir;
  logic [CntW-1:0] pkts;
  logic [CntW-1:0] bytes;
} verdict_t;

class session_table_model;
  logic [KeyW-1:0] keys [Sessions];
  bit              live [Sessions];
  logic [31:0]     deadline [Sessions];
  logic [CntW-1:0] pkt_cnt [2*Sessions];
  logic [CntW-1:0] byte_cnt [2*Sessions];
  logic [31:0]     now;
  logic [9:0]      timeout;
  logic [7:0]      tcp_num;
  logic [7:0]      udp_num;
  verdict_t        expected_verdicts[$];
  int              errors;

  function new();
    now = '0; timeout = 10'd3; tcp_num = 8'd6; udp_num = 8'd17; errors = 0;
    foreach (live[i]) live[i] = 1'b0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [9:0] val);
    case (idx)
      CfgTimeout: timeout = val;
      CfgTcp:     tcp_num = val[7:0];
      CfgUdp:     udp_num = val[7:0];
      default: ;
    endcase
  endfunction

  function logic [CntW-1:0] sat_add(logic [CntW-1:0] a, logic [CntW-1:0] b);
    logic [CntW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CntW] ? CntMax : s[CntW-1:0];
  endfunction

  // Predict the verdict for one accepted input beat
  function void note_beat(bit kind, logic [InW-1:0] d);
    logic [KeyW-1:0] fwd, rev;
    verdict_t v;
    int slot, c;
    bit found, fresh, dir;
    if (kind) begin
      now = now + 32'd1;
      for (int i = 0; i < Sessions; i++) begin
        logic [31:0] diff;
        diff = now - deadline[i];
        if (live[i] && !diff[31]) live[i] = 1'b0;
      end
      return;
    end
    fwd = d[KeyW-1:0];
    rev = {d[103:96], d[79:64], d[95:80], d[31:0], d[63:32]};
    if (d[103:96] == tcp_num) v.route = RouteTcp;
    else if (d[103:96] == udp_num) v.route = RouteUdp;
    else v.route = RouteDrop;
    found = 1'b0; fresh = 1'b0; dir = 1'b0; slot = 0;
    for (int i = 0; i < Sessions && !found; i++) begin
      if (!live[i]) continue;
      if (keys[i] == fwd) begin found = 1'b1; slot = i; dir = 1'b0; end
      else if (keys[i] == rev) begin found = 1'b1; slot = i; dir = 1'b1; end
    end
    if (!found) begin
      for (int i = 0; i < Sessions && !found; i++) begin
        if (!live[i]) begin
          found = 1'b1; fresh = 1'b1; slot = i; dir = 1'b0;
          live[i] = 1'b1; keys[i] = fwd;
          pkt_cnt[2*i] = '0; pkt_cnt[2*i+1] = '0;
          byte_cnt[2*i] = '0; byte_cnt[2*i+1] = '0;
        end
      end
    end
    if (!found) begin
      // table full: only the route is meaningful
      v.tracked = 1'b0; v.is_new = 1'b0; v.slot = '0; v.dir = 1'b0;
      v.pkts = '0; v.bytes = '0;
    end else begin
      deadline[slot] = now + {22'd0, timeout};
      c = 2*slot + int'(dir);
      pkt_cnt[c] = sat_add(pkt_cnt[c], CntW'(1));
      byte_cnt[c] = sat_add(byte_cnt[c], CntW'(d[119:104]));
      v.tracked = 1'b1; v.is_new = fresh; v.slot = slot[9:0]; v.dir = dir;
      v.pkts = pkt_cnt[c]; v.bytes = byte_cnt[c];
    end
    expected_verdicts.push_back(v);
  endfunction

  task report(string what, logic [CntW-1:0] got, logic [CntW-1:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  task check_result(logic [OutW-1:0] q);
    verdict_t v;
    if (expected_verdicts.size() == 0) begin
      report("unexpected beat", q[CntW-1:0], '0);
      return;
    end
    v = expected_verdicts.pop_front();
    if (q[1:0] !== v.route)    report("route", CntW'(q[1:0]), CntW'(v.route));
    if (q[2] !== v.tracked)    report("tracked", CntW'(q[2]), CntW'(v.tracked));
    if (q[3] !== v.is_new)     report("is_new", CntW'(q[3]), CntW'(v.is_new));
    if (q[13:4] !== v.slot)    report("slot_index", CntW'(q[13:4]), CntW'(v.slot));
    if (q[14] !== v.dir)       report("direction", CntW'(q[14]), CntW'(v.dir));
    if (q[62:15] !== v.pkts)   report("packet_total", q[62:15], v.pkts);
    if (q[110:63] !== v.bytes) report("byte_total", q[110:63], v.bytes);
  endtask
endclass

module flow_session_tracker_core_test;
  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [InW-1:0] in_tdata = '0;
  logic in_tuser = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OutW-1:0] out_tdata;
  logic cfg_we = 0;
  logic [1:0] cfg_index = CfgTimeout;
  logic [9:0] cfg_wdata = '0;

  session_table_model model = new();
  int src_idle = 35;
  int dst_idle = 87;
  int beat_count = 0;
  int stall_left = 0;
  bit stall_done = 0;
  logic [InW-1:0] recent [8];

  flow_session_tracker_core uut (.*);

  initial forever #5 clk = ~clk;

  initial begin
    #300ms;
    $display("flow_session_tracker_core_test: FAIL");
    $finish;
  end

  // Result side: check each beat, then pick tready for the next edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) model.check_result(out_tdata);
    if (!stall_done && beat_count >= 120) begin
      stall_done = 1'b1;
      stall_left = 4000;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= dst_idle);
    end
  end

  function automatic logic [InW-1:0] pack_pkt(logic [31:0] sa, logic [31:0] da,
      logic [15:0] sp, logic [15:0] dp, logic [7:0] pr, logic [15:0] len);
    return {8'h0, len, pr, dp, sp, da, sa};
  endfunction

  function automatic logic [InW-1:0] swap_pkt(logic [InW-1:0] d);
    return {d[127:96], d[79:64], d[95:80], d[31:0], d[63:32]};
  endfunction

  task send_beat(bit kind, logic [InW-1:0] d);
    while ($urandom_range(99) < src_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    model.note_beat(kind, d);
    beat_count++;
  endtask

  // Drain, let any tick sweep finish, then write a register
  task write_reg(logic [1:0] idx, logic [9:0] val);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (model.expected_verdicts.size() != 0) @(posedge clk);
    repeat (2100) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    model.set_reg(idx, val);
  endtask

  function automatic logic [7:0] pick_proto();
    case ($urandom_range(3))
      0: return model.tcp_num;
      1: return model.udp_num;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [InW-1:0] random_pkt();
    return pack_pkt($urandom, $urandom, 16'($urandom), 16'($urandom),
                    pick_proto(), 16'($urandom));
  endfunction

  task random_beat();
    int r;
    logic [InW-1:0] d;
    r = $urandom_range(99);
    if (r < 12) begin
      send_beat(1'b1, {$urandom, $urandom, $urandom, $urandom});
    end else if (r < 65) begin
      d = recent[$urandom_range(7)];
      d[119:104] = 16'($urandom);
      send_beat(1'b0, $urandom_range(1) ? swap_pkt(d) : d);
    end else begin
      d = random_pkt();
      recent[$urandom_range(7)] = d;
      send_beat(1'b0, d);
    end
  endtask

  initial begin
    logic [InW-1:0] a;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (recent[i]) recent[i] = random_pkt();

    // Directed: extremes, swapped hits, symmetric tuple, aging, register writes
    a = pack_pkt('0, '0, '0, '0, 8'd6, '0);
    send_beat(1'b0, a);
    send_beat(1'b0, a);
    a = pack_pkt('1, '1, '1, '1, 8'd17, '1);
    send_beat(1'b0, a);
    send_beat(1'b0, a);
    a = pack_pkt(32'h0a000001, 32'hc0a80001, 16'd1234, 16'd80, 8'hff, 16'd1500);
    send_beat(1'b0, a);
    send_beat(1'b0, swap_pkt(a));
    send_beat(1'b0, swap_pkt(a));
    a = pack_pkt(32'h01020304, 32'h01020304, 16'd53, 16'd53, 8'd17, 16'd64);
    send_beat(1'b0, a);
    send_beat(1'b0, swap_pkt(a));
    send_beat(1'b1, '1);
    send_beat(1'b1, '0);
    send_beat(1'b0, a);
    send_beat(1'b1, '0);
    send_beat(1'b1, '0);
    send_beat(1'b0, a);
    write_reg(CfgTimeout, 10'd0);
    send_beat(1'b0, a);
    send_beat(1'b1, '0);
    send_beat(1'b0, a);
    write_reg(CfgTcp, 10'd17);
    write_reg(CfgUdp, 10'd17);
    send_beat(1'b0, pack_pkt(32'h11, 32'h22, 16'h1, 16'h2, 8'd17, 16'd9));
    write_reg(CfgUdp, 10'd255);
    write_reg(CfgTcp, 10'd0);
    send_beat(1'b0, pack_pkt(32'h33, 32'h44, 16'h3, 16'h4, 8'd255, 16'd7));
    send_beat(1'b0, pack_pkt(32'h33, 32'h44, 16'h3, 16'h4, 8'd0, 16'd7));
    write_reg(CfgTimeout, 10'd1023);
    write_reg(CfgTimeout, 10'd5);
    write_reg(CfgTcp, 10'd6);
    write_reg(CfgUdp, 10'd17);

    for (int i = 0; i < 180; i++) random_beat();
    write_reg(CfgTimeout, 10'd2);
    src_idle = 87;
    dst_idle = 35;
    for (int i = 0; i < 200; i++) random_beat();

    // Fill the table with long-lived sessions until it overflows
    write_reg(CfgTimeout, 10'd1023);
    src_idle = 0;
    dst_idle = 0;
    for (int i = 0; i < 1040; i++) begin
      a = pack_pkt({8'($urandom_range(255)), 24'(i)}, $urandom, 16'($urandom),
                   16'($urandom), pick_proto(), 16'($urandom));
      send_beat(1'b0, a);
      if (i % 64 == 0) recent[$urandom_range(7)] = a;
    end
    for (int i = 0; i < 20; i++) random_beat();

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (model.expected_verdicts.size() != 0) @(posedge clk);
    repeat (2100) @(posedge clk);
    if (model.errors == 0) $display("flow_session_tracker_core_test: PASS");
    else $display("flow_session_tracker_core_test: FAIL");
    $finish;
  end
endmodule
